### sv/tds_pkg.sv
`default_nettype none
package tds_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_W);
  localparam int IDX_OUT_W = 6;
  localparam int STAT_W    = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_ZERO_PIVOT,
    ST_SATURATED,
    ST_TOO_MANY_ROWS
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_Q,
    OP_MUL_X,
    OP_DEN,
    OP_NUM,
    OP_DIV_LD_P,
    OP_DIV_LD_Q,
    OP_DIV_STEP,
    OP_END_P,
    OP_END_Q,
    OP_RD,
    OP_X_INIT,
    OP_X_UPD
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             first;
    logic [ROW_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic clip;
  } dp_sts_t;

endpackage
`default_nettype wire

### sv/tds_row_if.sv
`default_nettype none
interface tds_row_if;
  logic                              valid;
  logic                              ready;
  logic signed [tds_pkg::DATA_W-1:0] sub_diag;
  logic signed [tds_pkg::DATA_W-1:0] main_diag;
  logic signed [tds_pkg::DATA_W-1:0] super_diag;
  logic signed [tds_pkg::DATA_W-1:0] rhs;
  logic                              last_row;

  modport source (output valid, sub_diag, main_diag, super_diag, rhs, last_row,
                  input ready);
  modport sink (input valid, sub_diag, main_diag, super_diag, rhs, last_row,
                output ready);
endinterface
`default_nettype wire

### sv/tds_sol_if.sv
`default_nettype none
interface tds_sol_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tds_pkg::DATA_W-1:0]    solution;
  logic        [tds_pkg::IDX_OUT_W-1:0] row_index;
  logic                                 last_result;
  logic        [tds_pkg::STAT_W-1:0]    status;

  modport source (output valid, solution, row_index, last_result, status,
                  input ready);
  modport sink (input valid, solution, row_index, last_result, status,
                output ready);
endinterface
`default_nettype wire

### sv/tds_dp.sv
`default_nettype none
module tds_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire tds_pkg::dp_cmd_t             cmd_i,
  input  wire signed [tds_pkg::DATA_W-1:0]  sub_diag_i,
  input  wire signed [tds_pkg::DATA_W-1:0]  main_diag_i,
  input  wire signed [tds_pkg::DATA_W-1:0]  super_diag_i,
  input  wire signed [tds_pkg::DATA_W-1:0]  rhs_i,
  input  wire                               last_row_i,
  output tds_pkg::dp_sts_t                  sts_o,
  output logic signed [tds_pkg::DATA_W-1:0] solution_o
);

  localparam int W    = tds_pkg::DATA_W;
  localparam int FB   = tds_pkg::FRAC_BITS;
  localparam int DW   = tds_pkg::DIV_W;
  localparam int NR   = tds_pkg::MAX_ROWS;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [DW-1:0] MAG_MAX = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DW-1:0] MAG_MIN = {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] a_q, b_q, c_q, d_q;
  logic signed [W-1:0] pprev_q, qprev_q, pcur_q;
  logic signed [W-1:0] prod_q, den_q, num_q, x_q;
  logic signed [W-1:0] rdp_q, rdq_q;
  logic [DW-1:0]       dvd_q;
  logic [W-1:0]        dvs_q, rem_q;
  logic                neg_q, clip_q;
  logic signed [W-1:0] ratio_mem  [NR];
  logic signed [W-1:0] offset_mem [NR];

  // multiplier operand select
  logic signed [W-1:0]   mx, my;
  logic signed [2*W-1:0] full, sh;
  logic signed [W-1:0]   mul_sat;
  logic                  mul_clip;

  always_comb begin
    case (cmd_i.op)
      tds_pkg::OP_MUL_P: begin mx = a_q;   my = pprev_q; end
      tds_pkg::OP_MUL_Q: begin mx = a_q;   my = qprev_q; end
      default:           begin mx = rdp_q; my = x_q;     end
    endcase
    full     = mx * my;
    sh       = full >>> FB;
    mul_clip = !((&sh[2*W-1:W-1]) || !(|sh[2*W-1:W-1]));
    mul_sat  = mul_clip ? (sh[2*W-1] ? SMIN : SMAX) : sh[W-1:0];
  end

  // saturating add / subtract
  logic signed [W-1:0] ax, ay, add_sat;
  logic                sub, add_clip;
  logic signed [W:0]   sum;

  always_comb begin
    case (cmd_i.op)
      tds_pkg::OP_DEN: begin ax = b_q;    ay = prod_q; sub = 1'b0; end
      tds_pkg::OP_NUM: begin ax = d_q;    ay = prod_q; sub = 1'b1; end
      default:         begin ax = prod_q; ay = rdq_q;  sub = 1'b0; end
    endcase
    sum      = sub ? ({ax[W-1], ax} - {ay[W-1], ay}) : ({ax[W-1], ax} + {ay[W-1], ay});
    add_clip = sum[W] != sum[W-1];
    add_sat  = add_clip ? (sum[W] ? SMIN : SMAX) : sum[W-1:0];
  end

  // divider step and result saturation
  logic [W:0]          trial;
  logic                fits;
  logic [W-1:0]        mag_c, mag_num, mag_den;
  logic signed [W-1:0] q_sat;
  logic                q_clip, den_zero;

  always_comb begin
    trial    = {rem_q, dvd_q[DW-1]};
    fits     = trial >= {1'b0, dvs_q};
    mag_c    = c_q[W-1] ? W'(-c_q) : W'(c_q);
    mag_num  = num_q[W-1] ? W'(-num_q) : W'(num_q);
    mag_den  = den_q[W-1] ? W'(-den_q) : W'(den_q);
    den_zero = den_q == '0;
    if (neg_q) begin
      q_clip = dvd_q > MAG_MIN;
      q_sat  = q_clip ? SMIN : W'(-dvd_q[W-1:0]);
    end else begin
      q_clip = dvd_q > MAG_MAX;
      q_sat  = q_clip ? SMAX : dvd_q[W-1:0];
    end
  end

  // clip flag, cleared at the start of each row and of back substitution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        tds_pkg::OP_LOAD, tds_pkg::OP_X_INIT: clip_q <= 1'b0;
        tds_pkg::OP_MUL_P, tds_pkg::OP_MUL_Q, tds_pkg::OP_MUL_X:
          clip_q <= clip_q | mul_clip;
        tds_pkg::OP_DEN:  clip_q <= clip_q | (add_clip & !cmd_i.first);
        tds_pkg::OP_NUM:  clip_q <= clip_q | (add_clip & !cmd_i.first);
        tds_pkg::OP_X_UPD: clip_q <= clip_q | add_clip;
        tds_pkg::OP_END_P, tds_pkg::OP_END_Q: clip_q <= clip_q | (q_clip & !den_zero);
        default: clip_q <= clip_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tds_pkg::OP_LOAD: begin
        a_q <= sub_diag_i;
        b_q <= main_diag_i;
        c_q <= last_row_i ? '0 : super_diag_i;
        d_q <= rhs_i;
      end
      tds_pkg::OP_MUL_P, tds_pkg::OP_MUL_Q, tds_pkg::OP_MUL_X: prod_q <= mul_sat;
      tds_pkg::OP_DEN: den_q <= cmd_i.first ? b_q : add_sat;
      tds_pkg::OP_NUM: num_q <= cmd_i.first ? d_q : add_sat;
      tds_pkg::OP_DIV_LD_P: begin
        dvd_q <= {mag_c, {FB{1'b0}}};
        dvs_q <= mag_den;
        rem_q <= '0;
        neg_q <= (!c_q[W-1] && (c_q != '0)) ^ den_q[W-1];
      end
      tds_pkg::OP_DIV_LD_Q: begin
        dvd_q <= {mag_num, {FB{1'b0}}};
        dvs_q <= mag_den;
        rem_q <= '0;
        neg_q <= num_q[W-1] ^ den_q[W-1];
      end
      tds_pkg::OP_DIV_STEP: begin
        rem_q <= fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
        dvd_q <= {dvd_q[DW-2:0], fits};
      end
      tds_pkg::OP_END_P: pcur_q <= den_zero ? '0 : q_sat;
      tds_pkg::OP_END_Q: begin
        pprev_q <= pcur_q;
        qprev_q <= den_zero ? '0 : q_sat;
      end
      tds_pkg::OP_X_INIT: x_q <= rdq_q;
      tds_pkg::OP_X_UPD:  x_q <= add_sat;
      default: ;
    endcase
  end

  // coefficient stores: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tds_pkg::OP_END_Q) begin
      ratio_mem[cmd_i.addr]  <= pcur_q;
      offset_mem[cmd_i.addr] <= den_zero ? '0 : q_sat;
    end else if (cmd_i.op == tds_pkg::OP_X_UPD) begin
      offset_mem[cmd_i.addr] <= add_sat;
    end
    if (cmd_i.op == tds_pkg::OP_RD) begin
      rdp_q <= ratio_mem[cmd_i.addr];
      rdq_q <= offset_mem[cmd_i.addr];
    end
  end

  assign sts_o.den_zero = den_zero;
  assign sts_o.clip     = clip_q;
  assign solution_o     = rdq_q;

endmodule
`default_nettype wire

### sv/tds_ctl.sv
`default_nettype none
module tds_ctl (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 row_valid_i,
  input  wire                                 row_last_i,
  output logic                                row_ready_o,
  input  wire tds_pkg::dp_sts_t               sts_i,
  output tds_pkg::dp_cmd_t                    cmd_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [tds_pkg::IDX_OUT_W-1:0]       out_row_o,
  output logic                                out_last_o,
  output logic [tds_pkg::STAT_W-1:0]          out_status_o
);

  localparam int RW = tds_pkg::ROW_W;
  localparam int CW = tds_pkg::CNT_W;
  localparam int DC = tds_pkg::DCNT_W;
  localparam logic [CW-1:0] FULL = CW'(tds_pkg::MAX_ROWS);
  localparam logic [DC-1:0] DLAST = DC'(tds_pkg::DIV_W - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_P, S_DEN, S_MUL_Q, S_NUM,
    S_DIVP_LD, S_DIVP_RUN, S_DIVP_END,
    S_DIVQ_LD, S_DIVQ_RUN, S_DIVQ_END, S_FWD_DONE,
    S_BS_RD0, S_BS_INIT, S_BS_RD, S_BS_MUL, S_BS_UPD, S_BS_DONE,
    S_EM_RD, S_EM_OUT
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       cnt_q;
  logic [RW-1:0]       idx_q;
  logic [DC-1:0]       dcnt_q;
  logic                last_q;
  tds_pkg::status_e    err_q;
  logic                first;

  assign first = cnt_q == '0;

  // command decode
  always_comb begin
    cmd_o.first = first;
    cmd_o.addr  = (state_q == S_DIVQ_END) ? cnt_q[RW-1:0] : idx_q;
    case (state_q)
      S_IDLE:     cmd_o.op = row_valid_i ? tds_pkg::OP_LOAD : tds_pkg::OP_NONE;
      S_MUL_P:    cmd_o.op = tds_pkg::OP_MUL_P;
      S_DEN:      cmd_o.op = tds_pkg::OP_DEN;
      S_MUL_Q:    cmd_o.op = tds_pkg::OP_MUL_Q;
      S_NUM:      cmd_o.op = tds_pkg::OP_NUM;
      S_DIVP_LD:  cmd_o.op = tds_pkg::OP_DIV_LD_P;
      S_DIVQ_LD:  cmd_o.op = tds_pkg::OP_DIV_LD_Q;
      S_DIVP_RUN, S_DIVQ_RUN: cmd_o.op = tds_pkg::OP_DIV_STEP;
      S_DIVP_END: cmd_o.op = tds_pkg::OP_END_P;
      S_DIVQ_END: cmd_o.op = tds_pkg::OP_END_Q;
      S_BS_RD0, S_BS_RD, S_EM_RD: cmd_o.op = tds_pkg::OP_RD;
      S_BS_INIT:  cmd_o.op = tds_pkg::OP_X_INIT;
      S_BS_MUL:   cmd_o.op = tds_pkg::OP_MUL_X;
      S_BS_UPD:   cmd_o.op = tds_pkg::OP_X_UPD;
      default:    cmd_o.op = tds_pkg::OP_NONE;
    endcase
  end

  assign row_ready_o  = state_q == S_IDLE;
  assign out_valid_o  = state_q == S_EM_OUT;
  assign out_row_o    = tds_pkg::IDX_OUT_W'(idx_q);
  assign out_last_o   = idx_q == '0;
  assign out_status_o = err_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
      last_q  <= 1'b0;
      err_q   <= tds_pkg::ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (row_valid_i) begin
            last_q <= row_last_i;
            if (cnt_q == FULL) begin
              // drop the row; a final row still solves what is stored
              if (err_q == tds_pkg::ST_OK) err_q <= tds_pkg::ST_TOO_MANY_ROWS;
              idx_q <= RW'(cnt_q - 1'b1);
              if (row_last_i) state_q <= S_BS_RD0;
            end else begin
              state_q <= first ? S_DEN : S_MUL_P;
            end
          end
        end
        S_MUL_P: state_q <= S_DEN;
        S_DEN:   state_q <= first ? S_NUM : S_MUL_Q;
        S_MUL_Q: state_q <= S_NUM;
        S_NUM:   state_q <= S_DIVP_LD;
        S_DIVP_LD: begin
          dcnt_q  <= DLAST;
          state_q <= S_DIVP_RUN;
        end
        S_DIVP_RUN: begin
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == '0) state_q <= S_DIVP_END;
        end
        S_DIVP_END: state_q <= S_DIVQ_LD;
        S_DIVQ_LD: begin
          dcnt_q  <= DLAST;
          state_q <= S_DIVQ_RUN;
        end
        S_DIVQ_RUN: begin
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == '0) state_q <= S_DIVQ_END;
        end
        S_DIVQ_END: state_q <= S_FWD_DONE;
        S_FWD_DONE: begin
          // zero pivot outranks saturation within a row
          if (err_q == tds_pkg::ST_OK) begin
            if (sts_i.den_zero)  err_q <= tds_pkg::ST_ZERO_PIVOT;
            else if (sts_i.clip) err_q <= tds_pkg::ST_SATURATED;
          end
          idx_q   <= cnt_q[RW-1:0];
          cnt_q   <= cnt_q + 1'b1;
          state_q <= last_q ? S_BS_RD0 : S_IDLE;
        end
        S_BS_RD0: state_q <= S_BS_INIT;
        S_BS_INIT: begin
          if (idx_q == '0) begin
            state_q <= S_BS_DONE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_BS_RD;
          end
        end
        S_BS_RD:  state_q <= S_BS_MUL;
        S_BS_MUL: state_q <= S_BS_UPD;
        S_BS_UPD: begin
          if (idx_q == '0) begin
            state_q <= S_BS_DONE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_BS_RD;
          end
        end
        S_BS_DONE: begin
          if (err_q == tds_pkg::ST_OK && sts_i.clip) err_q <= tds_pkg::ST_SATURATED;
          idx_q   <= RW'(cnt_q - 1'b1);
          state_q <= S_EM_RD;
        end
        S_EM_RD: state_q <= S_EM_OUT;
        S_EM_OUT: begin
          if (out_ready_i) begin
            if (idx_q == '0) begin
              cnt_q   <= '0;
              err_q   <= tds_pkg::ST_OK;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/tridiagonal_system_solver.sv
`default_nettype none
// Thomas-algorithm solver for tridiagonal systems in signed Q16.16. Rows are
// taken one at a time on row_i; each accepted row runs forward elimination
// through one shared 32x32 multiplier and a one-bit-per-cycle restoring
// divider of 48 steps, which is run twice per row (ratio and offset). The
// row marked last_row then starts back substitution, which reads, multiplies
// and updates each row below the top one in turn, after which the solutions
// leave on sol_o from the highest row down to row 0, each beat held until the
// sink takes it. No row is accepted until the beat for row 0 has been taken.
// status is the same on every beat of a run.
module tridiagonal_system_solver (
  input wire        clk_i,
  input wire        rst_ni,
  tds_row_if.sink   row_i,
  tds_sol_if.source sol_o
);

  tds_pkg::dp_cmd_t cmd;
  tds_pkg::dp_sts_t sts;

  tds_ctl u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_valid_i  (row_i.valid),
    .row_last_i   (row_i.last_row),
    .row_ready_o  (row_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .out_valid_o  (sol_o.valid),
    .out_ready_i  (sol_o.ready),
    .out_row_o    (sol_o.row_index),
    .out_last_o   (sol_o.last_result),
    .out_status_o (sol_o.status)
  );

  tds_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sub_diag_i   (row_i.sub_diag),
    .main_diag_i  (row_i.main_diag),
    .super_diag_i (row_i.super_diag),
    .rhs_i        (row_i.rhs),
    .last_row_i   (row_i.last_row),
    .sts_o        (sts),
    .solution_o   (sol_o.solution)
  );

  // never take a row while a solution beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_i.ready && sol_o.valid))
    else $error("row accepted during emission");

  // the closing beat belongs to row zero
  a_last_is_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sol_o.valid && sol_o.last_result) |-> (sol_o.row_index == '0))
    else $error("last_result on nonzero row");

  // after the closing beat the block takes rows again
  a_ready_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sol_o.valid && sol_o.ready && sol_o.last_result) |=> row_i.ready)
    else $error("not ready after run");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_ROWS    = 260;
  localparam int ONE            = 1 << tds_pkg::FRAC_BITS;

  typedef struct {
    logic signed [tds_pkg::DATA_W-1:0] sub_diag;
    logic signed [tds_pkg::DATA_W-1:0] main_diag;
    logic signed [tds_pkg::DATA_W-1:0] super_diag;
    logic signed [tds_pkg::DATA_W-1:0] rhs;
    logic                              last_row;
  } row_t;

  typedef struct {
    logic signed [tds_pkg::DATA_W-1:0] solution;
    logic [tds_pkg::IDX_OUT_W-1:0]     row_index;
    logic                              last_result;
    tds_pkg::status_e                  status;
  } unknown_t;

  // Thomas elimination model plus the queue of unknowns still owed by the block
  class tds_scoreboard;
    int               ratio_mem[tds_pkg::MAX_ROWS];
    int               offset_mem[tds_pkg::MAX_ROWS];
    int               rows_held;
    tds_pkg::status_e run_status;
    bit               clip;
    unknown_t         owed[$];
    int               mismatches;

    function new();
      rows_held  = 0;
      run_status = tds_pkg::ST_OK;
      mismatches = 0;
    endfunction

    function int clamp(longint v);
      if (v > 64'sd2147483647) begin
        clip = 1;
        return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
        clip = 1;
        return 32'sh80000000;
      end
      return int'(v);
    endfunction

    // floor-rounded fixed-point product
    function int qmul(int x, int y);
      longint p;
      p = longint'(x) * longint'(y);
      return clamp(p >>> tds_pkg::FRAC_BITS);
    endfunction

    // quotient truncated toward zero
    function int qdiv(longint num, int den);
      longint scaled;
      scaled = num * (longint'(1) << tds_pkg::FRAC_BITS);
      return clamp(scaled / longint'(den));
    endfunction

    function void flag(tds_pkg::status_e s);
      if (run_status == tds_pkg::ST_OK) run_status = s;
    endfunction

    function void note_row(row_t r);
      int      den, num, p, q, cc, x, n;
      int      sol[tds_pkg::MAX_ROWS];
      unknown_t u;
      clip = 0;
      if (rows_held < tds_pkg::MAX_ROWS) begin
        cc = r.last_row ? 0 : r.super_diag;
        p  = 0;
        q  = 0;
        if (rows_held == 0) begin
          den = r.main_diag;
          num = r.rhs;
        end else begin
          den = clamp(longint'(r.main_diag) + qmul(r.sub_diag, ratio_mem[rows_held-1]));
          num = clamp(longint'(r.rhs) - qmul(r.sub_diag, offset_mem[rows_held-1]));
        end
        if (den == 0) begin
          flag(tds_pkg::ST_ZERO_PIVOT);
        end else begin
          p = qdiv(-longint'(cc), den);
          q = qdiv(longint'(num), den);
        end
        if (clip) flag(tds_pkg::ST_SATURATED);
        ratio_mem[rows_held]  = p;
        offset_mem[rows_held] = q;
        rows_held++;
      end else begin
        flag(tds_pkg::ST_TOO_MANY_ROWS);
      end
      if (!r.last_row) return;
      n = rows_held;
      if (n == 0) return;
      // back substitution from the top row down
      clip = 0;
      x = offset_mem[n-1];
      sol[n-1] = x;
      for (int i = n - 1; i > 0; i--) begin
        x = clamp(longint'(qmul(ratio_mem[i-1], x)) + offset_mem[i-1]);
        sol[i-1] = x;
      end
      if (clip) flag(tds_pkg::ST_SATURATED);
      for (int i = n - 1; i >= 0; i--) begin
        u.solution    = sol[i];
        u.row_index   = i[tds_pkg::IDX_OUT_W-1:0];
        u.last_result = (i == 0);
        u.status      = run_status;
        owed.insert(owed.size(), u);
      end
      rows_held  = 0;
      run_status = tds_pkg::ST_OK;
    endfunction

    function void check_result(unknown_t got);
      unknown_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: solution %h row %0d", got.solution, got.row_index);
        return;
      end
      want = owed.pop_front();
      if (got.solution !== want.solution || got.row_index !== want.row_index ||
          got.last_result !== want.last_result || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h row=%0d last=%b st=%0d, got x=%h row=%0d last=%b st=%0d",
                   want.solution, want.row_index, want.last_result, want.status,
                   got.solution, got.row_index, got.last_result, got.status);
      end
    endfunction

    function int owed_count();
      return owed.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tds_row_if row_ch ();
  tds_sol_if sol_ch ();

  tridiagonal_system_solver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .row_i  (row_ch.sink),
    .sol_o  (sol_ch.source)
  );

  tds_scoreboard sb = new();
  bit calm;
  int stall_left;
  int quiet_cycles;
  int rows_sent;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // short gaps mostly, a long one now and then
  function int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // hold valid until the row beat is taken
  task automatic send_row(input int a, input int b, input int c, input int d,
                          input bit last);
    int gap;
    row_t r;
    gap = pick_gap();
    if (gap > 0) begin
      row_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_ch.valid      <= 1'b1;
    row_ch.sub_diag   <= a;
    row_ch.main_diag  <= b;
    row_ch.super_diag <= c;
    row_ch.rhs        <= d;
    row_ch.last_row   <= last;
    do @(posedge clk_i); while (!row_ch.ready);
    r.sub_diag   = a;
    r.main_diag  = b;
    r.super_diag = c;
    r.rhs        = d;
    r.last_row   = last;
    sb.note_row(r);
    rows_sent++;
  endtask

  function int small_q(int mag);
    return $signed($urandom_range(0, 2 * mag * ONE)) - mag * ONE;
  endfunction

  function int wild_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      default: return $urandom();
    endcase
  endfunction

  // well-formed system mostly, noisy rows sometimes
  task automatic send_system(input int n);
    int b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_row(wild_q(), wild_q(), wild_q(), wild_q(), i == n - 1);
      end else begin
        b = $urandom_range(3 * ONE, 8 * ONE);
        if ($urandom_range(0, 1)) b = -b;
        send_row(small_q(1), b, small_q(1), small_q(16), i == n - 1);
      end
    end
  endtask

  // accept and check solution beats; randomize ready
  always @(posedge clk_i) begin
    unknown_t got;
    if (rst_ni && sol_ch.valid && sol_ch.ready) begin
      got.solution    = sol_ch.solution;
      got.row_index   = sol_ch.row_index;
      got.last_result = sol_ch.last_result;
      got.status      = tds_pkg::status_e'(sol_ch.status);
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      sol_ch.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      sol_ch.ready <= (stall_left == 0);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((row_ch.valid && row_ch.ready) || (sol_ch.valid && sol_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    rst_ni            = 1'b0;
    row_ch.valid      = 1'b0;
    row_ch.sub_diag   = '0;
    row_ch.main_diag  = '0;
    row_ch.super_diag = '0;
    row_ch.rhs        = '0;
    row_ch.last_row   = 1'b0;
    sol_ch.ready      = 1'b0;
    stall_left        = 0;
    quiet_cycles      = 0;
    rows_sent         = 0;
    calm              = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-row systems: plain, zero pivot, saturating quotient
    send_row(ONE, ONE, ONE, ONE, 1);
    send_row(5 * ONE, 0, 3 * ONE, ONE, 1);
    send_row(0, 1, 0, 32'sh7fffffff, 1);
    send_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1);
    // three-row system, nonzero sub on row 0 and super on last are ignored
    send_row(7 * ONE, 4 * ONE, ONE, 2 * ONE, 0);
    send_row(ONE, 4 * ONE, -ONE, -3 * ONE, 0);
    send_row(-ONE, 4 * ONE, 9 * ONE, 5 * ONE, 1);
    // zero pivot in the middle, then saturation keeps the first error
    send_row(0, ONE, ONE, ONE, 0);
    send_row(ONE, ONE, ONE, ONE, 0);
    send_row(32'sh7fffffff, 1, 0, 32'sh7fffffff, 1);
    // all-max and all-min rows
    send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
    send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
    // negative tiny values exercise quotient truncation toward zero
    send_row(0, -3 * ONE, -1, -1, 0);
    send_row(-1, 3 * ONE, 1, -ONE, 1);

    // full store, then an overflow row carrying last_row
    calm = 1;
    for (int i = 0; i < tds_pkg::MAX_ROWS; i++)
      send_row(small_q(1), 4 * ONE + $urandom_range(0, ONE), small_q(1), small_q(8), 0);
    calm = 0;
    send_row(ONE, ONE, ONE, ONE, 1);

    while (rows_sent < RANDOM_ROWS) begin
      calm = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_system(n);
    end
    row_ch.valid <= 1'b0;

    while (sb.owed_count() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_count() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
